FILE: hdl/pmc_pkg.sv
// Shared constants, codes and widths of the pH probe median calibrate unit.
`default_nettype none
package pmc_pkg;

	localparam int WINDOW_DEPTH = 15;
	localparam int WIN_AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

	// Shared divider width, wide enough for the pH dividend.
	localparam int DIV_W = 49;
	localparam int DIV_CW = $clog2(DIV_W + 1);

	localparam int CFG_IDX_W = 2;

	typedef enum logic [2:0] {
		ACT_SAMPLE  = 3'd0,
		ACT_UNKNOWN = 3'd1,
		ACT_ENTER   = 3'd2,
		ACT_CAPTURE = 3'd3,
		ACT_EXIT    = 3'd4
	} action_t;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_ENTERED    = 4'd1,
		ST_NEUTRAL    = 4'd2,
		ST_ACID       = 4'd3,
		ST_BUF_ERR    = 4'd4,
		ST_CMD_ERR    = 4'd5,
		ST_SUCCESS    = 4'd6,
		ST_FAILED     = 4'd7,
		ST_TEMP_RANGE = 4'd8
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_REF_VOLTAGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 2'd1;

	localparam logic [15:0] NEUTRAL_DEFAULT = 16'd26080;
	localparam logic [15:0] ACID_DEFAULT    = 16'd31250;
	localparam logic [15:0] NEUTRAL_LOW     = 16'd24580;
	localparam logic [15:0] NEUTRAL_HIGH    = 16'd27580;
	localparam logic [15:0] ACID_LOW        = 16'd29750;
	localparam logic [15:0] ACID_HIGH       = 16'd32750;
	localparam logic signed [15:0] TEMP_DEFAULT = 16'sd2500;
	localparam logic signed [15:0] TEMP_MAX     = 16'sd10000;
	localparam logic [15:0] REF_V_DEFAULT   = 16'd50000;
	localparam logic [12:0] FULL_SCALE_DEFAULT = 13'd1024;

	localparam logic signed [20:0] ACID_SPAN_SCALE = 21'sd1000000;
	localparam logic signed [17:0] TEMP_SLOPE      = 18'sd56544;
	localparam logic [31:0]        PH_NUM_SCALE    = 32'd2850000000;
	localparam logic [DIV_W-1:0]   PH_Q_CAP        = DIV_W'(1000000);
	localparam logic signed [21:0] PH_NEUTRAL_MILLI = 22'sd6860;

endpackage
`default_nettype wire

FILE: hdl/pmc_window.sv
// Sample window memory: one write port, two registered read ports, per-entry valid bits.
`default_nettype none
module pmc_window (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [pmc_pkg::WIN_AW-1:0] wr_addr,
	input  wire logic [11:0]               wr_data,
	input  wire logic [pmc_pkg::WIN_AW-1:0] rd_addr_a,
	input  wire logic [pmc_pkg::WIN_AW-1:0] rd_addr_b,
	output logic      [11:0]               rd_data_a,
	output logic      [11:0]               rd_data_b
);
	import pmc_pkg::*;

	logic [11:0]             mem [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] vld_q;
	logic [11:0]             raw_a_q, raw_b_q;
	logic                    va_q, vb_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		raw_a_q <= mem[rd_addr_a];
		raw_b_q <= mem[rd_addr_b];
	end

	// An entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			va_q <= vld_q[rd_addr_a];
			vb_q <= vld_q[rd_addr_b];
		end
	end

	assign rd_data_a = va_q ? raw_a_q : 12'd0;
	assign rd_data_b = vb_q ? raw_b_q : 12'd0;

endmodule
`default_nettype wire

FILE: hdl/pmc_median.sv
// Median by rank counting: each candidate entry is compared against every entry.
`default_nettype none
module pmc_median (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [pmc_pkg::WIN_AW-1:0] wr_addr,
	input  wire logic [11:0]               wr_data,
	input  wire logic                      start,
	output logic                           done,
	output logic      [11:0]               median
);
	import pmc_pkg::*;

	localparam logic [CNT_W-1:0]  K_LO = CNT_W'((WINDOW_DEPTH - 1) / 2);
	localparam logic [CNT_W-1:0]  K_HI = CNT_W'(WINDOW_DEPTH / 2);
	localparam logic [WIN_AW-1:0] LAST = WIN_AW'(WINDOW_DEPTH - 1);

	logic              busy_q;
	logic [WIN_AW-1:0] i_q, j_q;
	logic              v_s1, jlast_s1, ilast_s1;
	logic [CNT_W-1:0]  lt_q, le_q, lt_n, le_n;
	logic [11:0]       lo_q, hi_q, rd_a, rd_b;
	logic              done_q;

	pmc_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(i_q),
		.rd_addr_b(j_q),
		.rd_data_a(rd_a),
		.rd_data_b(rd_b)
	);

	always_comb begin
		lt_n = lt_q + CNT_W'(rd_b < rd_a);
		le_n = le_q + CNT_W'(rd_b <= rd_a);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			v_s1     <= 1'b0;
			jlast_s1 <= 1'b0;
			ilast_s1 <= 1'b0;
			lt_q     <= '0;
			le_q     <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			v_s1     <= busy_q;
			jlast_s1 <= (j_q == LAST);
			ilast_s1 <= (i_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				j_q    <= '0;
				lt_q   <= '0;
				le_q   <= '0;
			end else if (busy_q) begin
				if (j_q == LAST) begin
					j_q <= '0;
					if (i_q == LAST) begin
						busy_q <= 1'b0;
						i_q    <= '0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (v_s1) begin
				if (jlast_s1) begin
					lt_q <= '0;
					le_q <= '0;
					if (ilast_s1) begin
						done_q <= 1'b1;
					end
				end else begin
					lt_q <= lt_n;
					le_q <= le_n;
				end
			end
		end
	end

	// The candidate whose rank range covers the middle position holds the answer.
	always_ff @(posedge clk) begin
		if (v_s1 && jlast_s1) begin
			if (lt_n <= K_LO && K_LO < le_n) begin
				lo_q <= rd_a;
			end
			if (lt_n <= K_HI && K_HI < le_n) begin
				hi_q <= rd_a;
			end
		end
	end

	logic [12:0] mid_sum;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign median  = mid_sum[12:1];
	assign done    = done_q;

endmodule
`default_nettype wire

FILE: hdl/pmc_divider.sv
// Restoring divider, one quotient bit per cycle, shared by voltage scaling and pH.
`default_nettype none
module pmc_divider (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [pmc_pkg::DIV_W-1:0] dividend,
	input  wire logic [pmc_pkg::DIV_W-1:0] divisor,
	output logic                          done,
	output logic      [pmc_pkg::DIV_W-1:0] quotient
);
	import pmc_pkg::*;

	logic [DIV_W:0]    rem_q, rem_sh, rem_sub;
	logic [DIV_W-1:0]  quo_q, dvs_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q, done_q, fits;

	always_comb begin
		rem_sh  = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits    = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub : rem_sh;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: hdl/ph_probe_median_calibrate_unit.sv
// Top level of the pH probe median calibrate unit.
// Usage:
// An input transaction on s_* carries an action in s_tuser and the sample and
// probe fields in s_tdata. A sample action writes the ADC count into a ring
// window and converts the window median into pH. Calibration actions latch
// the probe voltage and temperature and step the enter, capture and exit
// session. Each input transaction yields exactly one output transaction on
// m_*, with the status code in m_tuser.
// The median is found by rank counting over the window memory, WINDOW_DEPTH
// squared reads. Scaling to voltage takes one multiply and a pass through
// the shared divider; a sample in temperature range adds product, sum and
// absolute-value steps and a second divider pass.
// One item is worked at a time: s_tready is high only when the unit is idle.
// The finished result sits in an output register, so the next item is taken
// while it waits; a stalled receiver blocks only the following completion.
// Reset clears the window to zeros, restores the default calibration
// voltages, the reference temperature and both configuration registers, and
// closes any calibration session. The cfg_* channel is always ready.
`default_nettype none
module ph_probe_median_calibrate_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// tdata: adc_sample[11:0], solution_temperature[27:12],
	// probe_voltage[43:28], probe_temperature[59:44], zeros above.
	input  wire logic [63:0]                 s_tdata,
	// tuser: action[2:0].
	input  wire logic [2:0]                  s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// tdata: ph_milli[15:0], median_count[27:16], filtered_voltage[43:28],
	// persist_neutral[44], persist_acid[45], persist_temperature[46], zero[47].
	output logic      [47:0]                 m_tdata,
	// tuser: status[3:0].
	output logic      [3:0]                  m_tuser,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [pmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                 cfg_data
);
	import pmc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MED, S_SMUL, S_SDIV_GO, S_SDIV, S_PMUL, S_PSUM, S_PABS,
		S_PDIV_GO, S_PDIV, S_PFIN, S_OUT
	} state_t;

	state_t state_q;

	logic [15:0]       ref_v_q;
	logic [12:0]       fs_q, fs_eff;
	logic [WIN_AW-1:0] wpos_q;
	logic [15:0]       neutral_q, acid_q;
	logic signed [15:0] ref_temp_q, sol_temp_q;
	logic              session_q, capdone_q;
	logic              is_sample_q;
	status_t           status_q;
	logic              pn_q, pa_q, pt_q;
	logic [11:0]       med_q;
	logic [15:0]       volt_q;
	logic [DIV_W-1:0]  prod_q;
	logic signed [38:0] pa_prod_q;
	logic signed [35:0] pt_prod_q;
	logic [47:0]       an_q;
	logic              nneg_q, nzero_q;
	logic signed [39:0] d_q;
	logic [DIV_W-1:0]  ad_q;
	logic              dneg_q, dzero_q;
	logic signed [15:0] ph_q;

	logic              m_tvalid_q;
	logic [47:0]       m_tdata_q;
	logic [3:0]        m_tuser_q;

	logic              accept;
	action_t           act;
	logic [11:0]       in_adc;
	logic signed [15:0] in_stemp, in_ptemp;
	logic [15:0]       in_pv;
	logic              in_neutral, in_acid;

	logic              med_done;
	logic [11:0]       med_val;
	logic              div_go, div_done;
	logic [DIV_W-1:0]  div_num, div_den, div_quo;

	function automatic logic dzero_calc(input logic signed [39:0] d);
		return d == 40'sd0;
	endfunction

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign act       = action_t'(s_tuser);
	assign in_adc    = s_tdata[11:0];
	assign in_stemp  = s_tdata[27:12];
	assign in_pv     = s_tdata[43:28];
	assign in_ptemp  = s_tdata[59:44];

	assign in_neutral = (in_pv > NEUTRAL_LOW) && (in_pv < NEUTRAL_HIGH);
	assign in_acid    = (in_pv > ACID_LOW) && (in_pv < ACID_HIGH);
	assign fs_eff     = (fs_q == 13'd0) ? 13'd1 : fs_q;

	pmc_median u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && act == ACT_SAMPLE),
		.wr_addr(wpos_q),
		.wr_data(in_adc),
		.start  (accept),
		.done   (med_done),
		.median (med_val)
	);

	// The divider serves the voltage scaling first, then the pH quotient.
	always_comb begin
		div_go  = (state_q == S_SDIV_GO) || (state_q == S_PDIV_GO);
		div_num = prod_q;
		div_den = DIV_W'(fs_eff);
		if (state_q == S_PDIV_GO) begin
			div_num = DIV_W'(an_q) + (ad_q >> 1);
			div_den = ad_q;
		end
	end

	pmc_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_go),
		.dividend(div_num),
		.divisor (div_den),
		.done    (div_done),
		.quotient(div_quo)
	);

	// pH result from the capped quotient, saturated to the signed 16-bit range.
	logic [DIV_W-1:0]   aq;
	logic signed [21:0] ph_sum;
	logic signed [15:0] ph_fin;
	always_comb begin
		aq     = (div_quo > PH_Q_CAP) ? PH_Q_CAP : div_quo;
		ph_sum = (nneg_q ^ dneg_q) ? PH_NEUTRAL_MILLI - $signed({1'b0, aq[20:0]})
		                           : PH_NEUTRAL_MILLI + $signed({1'b0, aq[20:0]});
		if (ph_sum > 22'sd32767) begin
			ph_fin = 16'sd32767;
		end else if (ph_sum < -22'sd32768) begin
			ph_fin = -16'sd32768;
		end else begin
			ph_fin = ph_sum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ref_v_q     <= REF_V_DEFAULT;
			fs_q        <= FULL_SCALE_DEFAULT;
			wpos_q      <= '0;
			neutral_q   <= NEUTRAL_DEFAULT;
			acid_q      <= ACID_DEFAULT;
			ref_temp_q  <= TEMP_DEFAULT;
			session_q   <= 1'b0;
			capdone_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// A new result is loaded when the output register is empty or drains now.
			if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_REF_VOLTAGE: ref_v_q <= cfg_data;
					REG_FULL_SCALE:  fs_q    <= cfg_data[12:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MED;
						if (act == ACT_SAMPLE) begin
							wpos_q <= (wpos_q == WIN_AW'(WINDOW_DEPTH - 1)) ?
							          '0 : wpos_q + 1'b1;
						end else begin
							ref_temp_q <= in_ptemp;
							unique case (act)
								ACT_ENTER: begin
									session_q <= 1'b1;
									capdone_q <= 1'b0;
								end
								ACT_CAPTURE: begin
									if (session_q) begin
										if (in_neutral) begin
											neutral_q <= in_pv;
											capdone_q <= 1'b1;
										end else if (in_acid) begin
											acid_q    <= in_pv;
											capdone_q <= 1'b1;
										end else begin
											capdone_q <= 1'b0;
										end
									end
								end
								ACT_EXIT: begin
									session_q <= 1'b0;
									capdone_q <= 1'b0;
								end
								default: ;
							endcase
						end
					end
				end
				S_MED:     if (med_done) state_q <= S_SMUL;
				S_SMUL:    state_q <= S_SDIV_GO;
				S_SDIV_GO: state_q <= S_SDIV;
				S_SDIV: begin
					if (div_done) begin
						if (is_sample_q && status_q == ST_OK) begin
							state_q <= S_PMUL;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_PMUL:    state_q <= S_PSUM;
				S_PSUM:    state_q <= S_PABS;
				S_PABS:    state_q <= dzero_calc(d_q) ? S_PFIN : S_PDIV_GO;
				S_PDIV_GO: state_q <= S_PDIV;
				S_PDIV:    if (div_done) state_q <= S_PFIN;
				S_PFIN:    state_q <= S_OUT;
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; the control flow above decides when each is used.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					is_sample_q <= (act == ACT_SAMPLE);
					sol_temp_q  <= in_stemp;
					pn_q        <= 1'b0;
					pa_q        <= 1'b0;
					pt_q        <= 1'b0;
					ph_q        <= 16'sd0;
					status_q    <= ST_OK;
					unique case (act)
						ACT_SAMPLE: begin
							if (in_stemp < 16'sd0 || in_stemp > TEMP_MAX) begin
								status_q <= ST_TEMP_RANGE;
							end
						end
						ACT_ENTER: status_q <= ST_ENTERED;
						ACT_CAPTURE: begin
							if (session_q) begin
								status_q <= in_neutral ? ST_NEUTRAL :
								            in_acid    ? ST_ACID    : ST_BUF_ERR;
							end
						end
						ACT_EXIT: begin
							if (session_q) begin
								if (capdone_q) begin
									status_q <= ST_SUCCESS;
									pn_q     <= in_neutral;
									pa_q     <= !in_neutral && in_acid;
									pt_q     <= (in_ptemp > 16'sd0) && (in_ptemp < TEMP_MAX);
								end else begin
									status_q <= ST_FAILED;
								end
							end
						end
						default: begin
							if (session_q) status_q <= ST_CMD_ERR;
						end
					endcase
				end
			end
			S_MED: begin
				if (med_done) med_q <= med_val;
			end
			S_SMUL: begin
				prod_q <= DIV_W'(med_q * ref_v_q) + DIV_W'(fs_eff >> 1);
			end
			S_SDIV: begin
				if (div_done) begin
					volt_q <= (div_quo > DIV_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
				end
			end
			S_PMUL: begin
				pa_prod_q <= ($signed({1'b0, acid_q}) - $signed({1'b0, neutral_q}))
				             * ACID_SPAN_SCALE;
				pt_prod_q <= (36'(sol_temp_q) - 36'(ref_temp_q)) * 36'(TEMP_SLOPE);
				an_q      <= ((neutral_q >= volt_q) ? neutral_q - volt_q : volt_q - neutral_q)
				             * PH_NUM_SCALE;
				nneg_q    <= neutral_q < volt_q;
				nzero_q   <= neutral_q == volt_q;
			end
			S_PSUM: begin
				d_q <= 40'(pa_prod_q) + 40'(pt_prod_q);
			end
			S_PABS: begin
				dneg_q  <= d_q[39];
				dzero_q <= dzero_calc(d_q);
				ad_q    <= d_q[39] ? DIV_W'(-d_q) : DIV_W'(d_q);
			end
			S_PFIN: begin
				if (dzero_q) begin
					ph_q <= nzero_q ? 16'sd6860 : (nneg_q ? -16'sd32768 : 16'sd32767);
				end else begin
					ph_q <= ph_fin;
				end
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {1'b0, pt_q, pa_q, pn_q, volt_q, med_q, ph_q};
					m_tuser_q <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
`default_nettype wire
